[rtl/xtok_pkg.sv]
// Package: shared types, codes and helpers for the XML tag/content tokenizer.
`default_nettype none
package xtok_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ClassW = 3;
  localparam int unsigned IdxW   = 7;
  localparam int unsigned EventW = 2;

  localparam logic [ByteW-1:0] ChLt     = 8'h3C;  // '<'
  localparam logic [ByteW-1:0] ChGt     = 8'h3E;  // '>'
  localparam logic [ByteW-1:0] ChSlash  = 8'h2F;  // '/'
  localparam logic [ByteW-1:0] ChQuest  = 8'h3F;  // '?'
  localparam logic [ByteW-1:0] ChBang   = 8'h21;  // '!'
  localparam logic [ByteW-1:0] ChEq     = 8'h3D;  // '='
  localparam logic [ByteW-1:0] ChDquote = 8'h22;  // '"'
  localparam logic [ByteW-1:0] ChSquote = 8'h27;  // '\''
  localparam logic [ByteW-1:0] ChNul    = 8'h00;

  typedef enum logic [10:0] {
    PH_CLEAD = 11'b000_0000_0001,
    PH_CBODY = 11'b000_0000_0010,
    PH_TLEAD = 11'b000_0000_0100,
    PH_SLASH = 11'b000_0000_1000,
    PH_NAME  = 11'b000_0001_0000,
    PH_SKIP  = 11'b000_0010_0000,
    PH_ALEAD = 11'b000_0100_0000,
    PH_ANAME = 11'b000_1000_0000,
    PH_ASEEK = 11'b001_0000_0000,
    PH_AVAL  = 11'b010_0000_0000,
    PH_TAIL  = 11'b100_0000_0000
  } phase_e;

  typedef enum logic [ClassW-1:0] {
    CLS_IGNORED = 3'd0,
    CLS_CONTENT = 3'd1,
    CLS_ELEM    = 3'd2,
    CLS_ANAME   = 3'd3,
    CLS_AVALUE  = 3'd4
  } class_e;

  typedef enum logic [EventW-1:0] {
    EV_NONE    = 2'd0,
    EV_CONTENT = 2'd1,
    EV_TAG     = 2'd2
  } event_e;

  // Parser state apart from the attribute counter, whose width is a parameter.
  typedef struct packed {
    phase_e phase;
    logic   quote_single;
    logic   closing;
    logic   opening;
  } pstate_t;

  typedef struct packed {
    class_e          byte_class;
    logic [IdxW-1:0] attr_index;
    event_e          event_res;
    logic            tag_is_start;
    logic            tag_is_end;
    logic [IdxW-1:0] attr_total;
  } result_t;

  function automatic logic is_ws(input logic [ByteW-1:0] c);
    is_ws = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

endpackage
`default_nettype wire

[rtl/xtok_step.sv]
// Single-byte step: next parser state and the result fields for one byte.
`default_nettype none
module xtok_step import xtok_pkg::*; #(
  parameter int unsigned MAX_ATTRS = 127,
  parameter int unsigned CntW      = $clog2(MAX_ATTRS + 1)
) (
  input  logic [ByteW-1:0] byte_i,
  input  pstate_t          state_i,
  input  logic [CntW-1:0]  count_i,
  output pstate_t          state_o,
  output logic [CntW-1:0]  count_o,
  output result_t          result_o
);

  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_ATTRS);

  logic ws;
  logic in_tag;
  logic full;
  logic [CntW-1:0] count_m1;

  assign ws       = is_ws(byte_i);
  assign full     = (count_i >= MaxCnt);
  assign count_m1 = count_i - CntW'(1);
  assign in_tag   = (state_i.phase == PH_TLEAD) || (state_i.phase == PH_SLASH) ||
                    (state_i.phase == PH_NAME)  || (state_i.phase == PH_SKIP)  ||
                    (state_i.phase == PH_ALEAD) || (state_i.phase == PH_ANAME) ||
                    (state_i.phase == PH_ASEEK) || (state_i.phase == PH_AVAL)  ||
                    (state_i.phase == PH_TAIL);

  always_comb begin
    state_o  = state_i;
    count_o  = count_i;
    result_o = '{byte_class: CLS_IGNORED, attr_index: '0, event_res: EV_NONE,
                 tag_is_start: 1'b0, tag_is_end: 1'b0, attr_total: '0};

    if (byte_i == ChNul) begin
      // end of document: drop everything
      state_o = '{phase: PH_CLEAD, quote_single: 1'b0, closing: 1'b0, opening: 1'b0};
      count_o = '0;
    end else if (in_tag && (byte_i == ChGt)) begin
      if ((state_i.phase != PH_TLEAD) && (state_i.phase != PH_SLASH) &&
          (state_i.phase != PH_SKIP)) begin
        result_o.event_res    = EV_TAG;
        result_o.tag_is_start = state_i.opening;
        result_o.tag_is_end   = state_i.closing;
        result_o.attr_total   = IdxW'(count_i);
      end
      state_o.phase = PH_CLEAD;
    end else begin
      unique case (state_i.phase)
        PH_TLEAD: begin
          if (ws) begin
            state_o.phase = PH_TLEAD;
          end else if (byte_i == ChSlash) begin
            state_o.opening = 1'b0;
            state_o.closing = 1'b1;
            state_o.phase   = PH_SLASH;
          end else if ((byte_i == ChQuest) || (byte_i == ChBang)) begin
            state_o.phase = PH_SKIP;
          end else begin
            result_o.byte_class = CLS_ELEM;
            state_o.phase       = PH_NAME;
          end
        end
        PH_SLASH: begin
          if ((byte_i == ChQuest) || (byte_i == ChBang)) begin
            state_o.phase = PH_SKIP;
          end else if (ws) begin
            state_o.phase = PH_TAIL;
          end else begin
            result_o.byte_class = CLS_ELEM;
            state_o.phase       = PH_NAME;
          end
        end
        PH_NAME: begin
          if (ws) begin
            state_o.phase = (state_i.closing || full) ? PH_TAIL : PH_ALEAD;
          end else begin
            result_o.byte_class = CLS_ELEM;
          end
        end
        PH_ALEAD: begin
          if (ws) begin
            state_o.phase = PH_ALEAD;
          end else if (byte_i == ChSlash) begin
            state_o.closing = 1'b1;
            state_o.phase   = PH_TAIL;
          end else if (byte_i == ChEq) begin
            state_o.phase = PH_ASEEK;
          end else begin
            result_o.byte_class = CLS_ANAME;
            result_o.attr_index = IdxW'(count_i);
            state_o.phase       = PH_ANAME;
          end
        end
        PH_ANAME: begin
          if (ws || (byte_i == ChEq)) begin
            state_o.phase = PH_ASEEK;
          end else begin
            result_o.byte_class = CLS_ANAME;
            result_o.attr_index = IdxW'(count_i);
          end
        end
        PH_ASEEK: begin
          // the attribute counts as soon as its opening quote arrives
          if ((byte_i == ChDquote) || (byte_i == ChSquote)) begin
            state_o.quote_single = (byte_i == ChSquote);
            count_o              = count_i + CntW'(1);
            state_o.phase        = PH_AVAL;
          end
        end
        PH_AVAL: begin
          if (byte_i == (state_i.quote_single ? ChSquote : ChDquote)) begin
            state_o.phase = full ? PH_TAIL : PH_ALEAD;
          end else begin
            result_o.byte_class = CLS_AVALUE;
            result_o.attr_index = IdxW'(count_m1);
          end
        end
        PH_SKIP, PH_TAIL: begin
          state_o.phase = state_i.phase;
        end
        default: begin
          // content phases, and any stray code treated as leading whitespace
          if (byte_i == ChLt) begin
            if (state_i.phase == PH_CBODY) begin
              result_o.event_res = EV_CONTENT;
            end
            state_o = '{phase: PH_TLEAD, quote_single: 1'b0, closing: 1'b0,
                        opening: 1'b1};
            count_o = '0;
          end else if ((state_i.phase == PH_CBODY) || !ws) begin
            result_o.byte_class = CLS_CONTENT;
            state_o.phase       = PH_CBODY;
          end else begin
            state_o.phase = PH_CLEAD;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/xml_tag_content_tokenizer_core.sv]
// Top level: input register, tokenizer step, parser state and result register.
//
//   channel  dir  tdata (low bit up)                                  tuser
//   s_axis   in   byte_in[7:0]                                        -
//   m_axis   out  byte_out[7:0] attr_index[14:8] event_res[16:15]     byte_class[2:0]
//                 tag_is_start[17] tag_is_end[18] attr_total[25:19]
//
// One byte per cycle while m_axis does not stall; a byte accepted on s_axis passes
// the input register, then the result register, before it shows on m_axis.
// The step logic is one pass of the parser FSM on the registered byte.
// Reset puts the parser in leading-content-whitespace and empties both stages.
// A stall on m_axis holds the result; the input stage takes one more request only if empty.
`default_nettype none
module xml_tag_content_tokenizer_core import xtok_pkg::*; #(
  parameter int unsigned MAX_ATTRS = 127
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_in[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // byte_out, attr_index, event_res, tag_is_start,
                                      // tag_is_end, attr_total, zero pad
  output logic [2:0]  m_axis_tuser    // byte_class[2:0]
);

  localparam int unsigned CntW = $clog2(MAX_ATTRS + 1);

  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_vld_q;
  logic [ByteW-1:0] out_byte_q;
  result_t          out_res_q;
  pstate_t          st_q, st_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  result_t          res_d;
  logic             advance;

  // step the registered byte whenever the result register is free or draining
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  xtok_step #(
    .MAX_ATTRS (MAX_ATTRS),
    .CntW      (CntW)
  ) u_step (
    .byte_i   (in_byte_q),
    .state_i  (st_q),
    .count_i  (cnt_q),
    .state_o  (st_d),
    .count_o  (cnt_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '{phase: PH_CLEAD, quote_single: 1'b0, closing: 1'b0, opening: 1'b0};
      cnt_q     <= '0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        st_q      <= st_d;
        cnt_q     <= cnt_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance) begin
      out_byte_q <= in_byte_q;
      out_res_q  <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_res_q.byte_class;
  assign m_axis_tdata  = {6'd0,
                          out_res_q.attr_total,
                          out_res_q.tag_is_end,
                          out_res_q.tag_is_start,
                          out_res_q.event_res,
                          out_res_q.attr_index,
                          out_byte_q};

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_ATTRS))
    else $error("attribute counter above limit");

  a_tag_markup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_res_q.event_res != EV_NONE) |-> out_res_q.byte_class == CLS_IGNORED)
    else $error("event on a classified byte");

  a_flags_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_res_q.event_res != EV_TAG) |->
      !out_res_q.tag_is_start && !out_res_q.tag_is_end && (out_res_q.attr_total == '0))
    else $error("tag fields set without tag event");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(st_q) && $stable(cnt_q))
    else $error("parser state moved without a step");

endmodule
`default_nettype wire
